@@ src/bsr_pkg.sv @@
// ----------------------------------------------------------------------------
// bsr_pkg
// Shared types, codes and helpers for the bone skinning block.
// ----------------------------------------------------------------------------
package bsr_pkg;

    localparam int unsigned MAX_BONES_DEF  = 256;
    localparam int unsigned BONE_SLOTS_DEF = 4;
    localparam int unsigned FRAC_BITS_DEF  = 16;

    localparam int unsigned XF_WORDS   = 12;
    localparam int unsigned BONE_WORDS = 21;
    localparam int unsigned ROW_CNT    = 6;   // 3 position rows, 3 normal rows
    localparam int unsigned IN_BYTES_W = 304;
    localparam int unsigned OUT_W      = 192;
    localparam int unsigned CNT_W      = 9;
    localparam int unsigned CFG_AW     = 1;

    typedef enum logic [2:0] {
        OP_OWN_WORD   = 3'd0,
        OP_OWNER_WORD = 3'd1,
        OP_SET_MAP    = 3'd2,
        OP_CLEAR_MAP  = 3'd3,
        OP_SKIN       = 3'd4
    } op_t;

    typedef enum logic [CFG_AW-1:0] {
        CFG_OWN_CNT   = 1'b0,
        CFG_OWNER_CNT = 1'b1
    } cfg_idx_t;

    // table and map write request, identical for every slot lane
    typedef struct packed {
        logic        tbl_we;
        logic        tbl_owner;
        logic [7:0]  entry;
        logic [4:0]  sel;
        logic [31:0] word;
        logic        map_we;
        logic [7:0]  map_tgt;
    } bsr_wr_t;

    typedef struct packed {
        logic [7:0] w;
        logic [7:0] bone;
        logic       own_ok;
        logic       remap;
    } slot_req_t;

    typedef struct packed {
        logic [ROW_CNT-1:0][32:0] val;
        logic                     fault;
    } lane_out_t;

    typedef struct packed {
        logic [31:0] q;
        logic [39:0] v;
    } div_t;

    // u = 255*q + v is kept; 256 = 255 + 1 folds the high part down
    function automatic div_t div255_step(input div_t d);
        div_t r;
        r.q = d.q + d.v[39:8];
        r.v = {8'd0, d.v[39:8]} + {32'd0, d.v[7:0]};
        return r;
    endfunction

    function automatic div_t div255_fix(input div_t d);
        div_t r;
        r = d;
        if (d.v >= 40'd255)
        begin
            r.q = d.q + 32'd1;
            r.v = d.v - 40'd255;
        end
        return r;
    endfunction

endpackage

@@ src/bsr_lane.sv @@
// ----------------------------------------------------------------------------
// bsr_lane
// One bone slot: remap lookup, bone table read, transform, weight and scale.
// ----------------------------------------------------------------------------
module bsr_lane #(
    parameter int unsigned MAX_BONES = bsr_pkg::MAX_BONES_DEF,
    parameter int unsigned FRAC_BITS = bsr_pkg::FRAC_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  bsr_pkg::bsr_wr_t        wr,
    input  bsr_pkg::slot_req_t      req,
    input  logic [8:0]              owner_cnt,
    input  logic [5:0][31:0]        vec,
    output bsr_pkg::lane_out_t      res
);

    localparam int unsigned ROWS  = (MAX_BONES < 256) ? MAX_BONES : 256;
    localparam int unsigned AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int unsigned DEPTH = 2 * ROWS;
    localparam int unsigned RAW   = $clog2(DEPTH);
    localparam int unsigned PW    = 64 - FRAC_BITS;
    localparam int unsigned SW    = PW + 2;

    logic [7:0]  tgt_mem [ROWS];
    logic [bsr_pkg::BONE_WORDS-1:0][31:0] tbl_mem [DEPTH];

    logic [RAW-1:0] waddr;
    logic [RAW-1:0] raddr;
    logic           tgt_ok;

    // stage 1
    logic [7:0] w1_reg, bone1_reg, tgt1_reg;
    logic       ok1_reg, flt1_reg, rv1_reg;
    // stage 2
    logic [bsr_pkg::BONE_WORDS-1:0][31:0] row2_reg;
    logic [7:0] w2_reg;
    logic       act2_reg, flt2_reg;
    // stage 3
    logic [5:0][2:0][PW-1:0] prod3_reg;
    logic [2:0][31:0]        trans3_reg;
    logic [7:0] w3_reg;
    logic       act3_reg, flt3_reg;
    // stage 4
    logic [5:0][31:0] sat4_reg;
    logic [7:0] w4_reg;
    logic       act4_reg, flt4_reg;
    // stage 5
    logic [5:0][39:0] u5_reg;
    logic [5:0]       neg5_reg;
    logic             act5_reg, flt5_reg;
    // stage 6
    bsr_pkg::div_t [5:0] d6_reg;
    logic [5:0]       neg6_reg;
    logic             act6_reg, flt6_reg;
    // stage 7
    logic [5:0][32:0] val7_reg;
    logic             flt7_reg;

    logic [5:0][2:0][PW-1:0] prod_next;
    logic [5:0][31:0]        sat_next;
    logic [5:0][39:0]        u_next;
    logic [5:0]              neg_next;
    bsr_pkg::div_t [5:0]     d_next;
    logic [5:0][32:0]        val_next;

    assign waddr = (wr.tbl_owner ? RAW'(ROWS) : RAW'(0)) + RAW'(wr.entry[AW-1:0]);
    assign raddr = rv1_reg ? (RAW'(ROWS) + RAW'(tgt1_reg[AW-1:0]))
                           : RAW'(bone1_reg[AW-1:0]);
    assign tgt_ok = ({1'b0, tgt1_reg} < owner_cnt) &&
                    (17'(tgt1_reg) < 17'(MAX_BONES));

    always_ff @(posedge clk)
    begin
        if (wr.map_we)
            tgt_mem[wr.entry[AW-1:0]] <= wr.map_tgt;
        if (wr.tbl_we)
            tbl_mem[waddr][wr.sel] <= wr.word;
    end

    always_comb
    begin
        for (int r = 0; r < 6; r++)
        begin
            logic [31:0] m;
            logic [31:0] x;
            logic [63:0] pr;
            for (int j = 0; j < 3; j++)
            begin
                m  = (r < 3) ? row2_reg[r * 4 + j]
                             : row2_reg[bsr_pkg::XF_WORDS + (r - 3) * 3 + j];
                x  = (r < 3) ? vec[j] : vec[3 + j];
                pr = {{32{m[31]}}, m} * {{32{x[31]}}, x};
                prod_next[r][j] = pr[63:FRAC_BITS];
            end
        end
    end

    always_comb
    begin
        for (int r = 0; r < 6; r++)
        begin
            logic [SW-1:0] s;
            s = {{2{prod3_reg[r][0][PW-1]}}, prod3_reg[r][0]} +
                {{2{prod3_reg[r][1][PW-1]}}, prod3_reg[r][1]} +
                {{2{prod3_reg[r][2][PW-1]}}, prod3_reg[r][2]};
            if (r < 3)
                s = s + {{(SW-32){trans3_reg[r][31]}}, trans3_reg[r]};
            if (!s[SW-1] && (|s[SW-2:31]))
                sat_next[r] = 32'h7FFF_FFFF;
            else if (s[SW-1] && !(&s[SW-2:31]))
                sat_next[r] = 32'h8000_0000;
            else
                sat_next[r] = s[31:0];
        end
    end

    always_comb
    begin
        for (int r = 0; r < 6; r++)
        begin
            logic [31:0] mag;
            neg_next[r] = sat4_reg[r][31];
            mag         = sat4_reg[r][31] ? (~sat4_reg[r] + 32'd1) : sat4_reg[r];
            u_next[r]   = {8'd0, mag} * {32'd0, w4_reg};
        end
    end

    always_comb
    begin
        for (int r = 0; r < 6; r++)
        begin
            bsr_pkg::div_t d;
            d.q = 32'd0;
            d.v = u5_reg[r];
            d   = bsr_pkg::div255_step(d);
            d_next[r] = bsr_pkg::div255_step(d);
        end
    end

    always_comb
    begin
        for (int r = 0; r < 6; r++)
        begin
            bsr_pkg::div_t d;
            d = bsr_pkg::div255_step(d6_reg[r]);
            d = bsr_pkg::div255_step(d);
            d = bsr_pkg::div255_fix(d);
            d = bsr_pkg::div255_fix(d);
            if (!act6_reg)
                val_next[r] = 33'd0;
            else if (neg6_reg[r])
                val_next[r] = ~{1'b0, d.q} + 33'd1;
            else
                val_next[r] = {1'b0, d.q};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok1_reg  <= 1'b0;
            flt1_reg <= 1'b0;
            act2_reg <= 1'b0;
            flt2_reg <= 1'b0;
            act3_reg <= 1'b0;
            flt3_reg <= 1'b0;
            act4_reg <= 1'b0;
            flt4_reg <= 1'b0;
            act5_reg <= 1'b0;
            flt5_reg <= 1'b0;
            act6_reg <= 1'b0;
            flt6_reg <= 1'b0;
            flt7_reg <= 1'b0;
        end
        else if (adv)
        begin
            ok1_reg  <= req.own_ok;
            flt1_reg <= (req.w != 8'd0) && !req.own_ok;
            act2_reg <= ok1_reg && (!rv1_reg || tgt_ok);
            flt2_reg <= flt1_reg || (ok1_reg && rv1_reg && !tgt_ok);
            act3_reg <= act2_reg;
            flt3_reg <= flt2_reg;
            act4_reg <= act3_reg;
            flt4_reg <= flt3_reg;
            act5_reg <= act4_reg;
            flt5_reg <= flt4_reg;
            act6_reg <= act5_reg;
            flt6_reg <= flt5_reg;
            flt7_reg <= flt6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w1_reg     <= req.w;
            bone1_reg  <= req.bone;
            rv1_reg    <= req.remap;
            tgt1_reg   <= tgt_mem[req.bone[AW-1:0]];
            row2_reg   <= tbl_mem[raddr];
            w2_reg     <= w1_reg;
            prod3_reg  <= prod_next;
            for (int i = 0; i < 3; i++)
                trans3_reg[i] <= row2_reg[i * 4 + 3];
            w3_reg     <= w2_reg;
            sat4_reg   <= sat_next;
            w4_reg     <= w3_reg;
            u5_reg     <= u_next;
            neg5_reg   <= neg_next;
            d6_reg     <= d_next;
            neg6_reg   <= neg5_reg;
            val7_reg   <= val_next;
        end
    end

    assign res.val   = val7_reg;
    assign res.fault = flt7_reg;

endmodule

@@ src/bone_skinning_with_owner_remap_top.sv @@
// ----------------------------------------------------------------------------
// bone_skinning_with_owner_remap_top
// Four-slot linear blend skinning with own/owner bone tables and remap.
// ----------------------------------------------------------------------------
// One request is taken every cycle, and the whole pipeline holds while a result
// waits; a skin vertex reaches the master side through the lane pipeline and
// the output register. Each slot lane keeps its own copy of the bone tables,
// one 21-word bone per memory row, so a slot reads a whole bone at once; table
// and map writes go to all copies at once. Remap valid bits reset to no remap.
module bone_skinning_with_owner_remap_top #(
    parameter int unsigned MAX_BONES  = bsr_pkg::MAX_BONES_DEF,
    parameter int unsigned BONE_SLOTS = bsr_pkg::BONE_SLOTS_DEF,
    parameter int unsigned FRAC_BITS  = bsr_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // entry, word_sel, word_value, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
    // bone_ids, weights; zero padded
    input  logic [bsr_pkg::IN_BYTES_W-1:0] s_tdata,
    // op
    input  logic [2:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // skin_x, skin_y, skin_z, skin_nx, skin_ny, skin_nz
    output logic [bsr_pkg::OUT_W-1:0]      m_tdata,
    // fault
    output logic                           m_tuser,
    input  logic                           cfg_we,
    input  logic [bsr_pkg::CFG_AW-1:0]     cfg_addr,
    input  logic [bsr_pkg::CNT_W-1:0]      cfg_wdata
);

    localparam int unsigned ROWS = (MAX_BONES < 256) ? MAX_BONES : 256;
    localparam int unsigned AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int unsigned ACW  = 34 + $clog2(BONE_SLOTS);
    localparam int unsigned LAT  = 7;

    logic [8:0]  own_cnt_reg, owner_cnt_reg;
    logic [ROWS-1:0] rmv_reg;
    logic [LAT-1:0]  vld_reg;
    logic        out_vld_reg;
    logic [5:0][31:0] out_reg;
    logic        out_flt_reg;
    logic [5:0][31:0] vec1_reg, vec2_reg;

    logic        adv, acc, vtx, ent_ok;
    logic [7:0]  entry;
    logic [4:0]  sel;
    logic [31:0] word;
    logic [5:0][31:0] vec_in;
    logic [31:0] ids, wts;
    bsr_pkg::bsr_wr_t wr;
    bsr_pkg::slot_req_t [BONE_SLOTS-1:0] req;
    bsr_pkg::lane_out_t [BONE_SLOTS-1:0] lres;
    logic [5:0][31:0] sum_next;
    logic             flt_next;

    assign adv      = !out_vld_reg || m_tready;
    assign s_tready = adv;
    assign acc      = s_tvalid && adv;

    assign entry  = s_tdata[7:0];
    assign sel    = s_tdata[12:8];
    assign word   = s_tdata[44:13];
    assign vec_in = s_tdata[236:45];
    assign ids    = s_tdata[268:237];
    assign wts    = s_tdata[300:269];

    assign ent_ok = 17'(entry) < 17'(MAX_BONES);
    assign vtx    = acc && (s_tuser == bsr_pkg::OP_SKIN) && (own_cnt_reg != 9'd0);

    always_comb
    begin
        wr.tbl_we    = acc && ent_ok && (sel <= 5'd20) &&
                       ((s_tuser == bsr_pkg::OP_OWN_WORD) ||
                        (s_tuser == bsr_pkg::OP_OWNER_WORD));
        wr.tbl_owner = (s_tuser == bsr_pkg::OP_OWNER_WORD);
        wr.entry     = entry;
        wr.sel       = sel;
        wr.word      = word;
        wr.map_we    = acc && ent_ok && (s_tuser == bsr_pkg::OP_SET_MAP);
        wr.map_tgt   = word[7:0];
    end

    always_comb
    begin
        for (int k = 0; k < BONE_SLOTS; k++)
        begin
            if (k < 4)
            begin
                req[k].w    = wts[k * 8 +: 8];
                req[k].bone = ids[k * 8 +: 8];
            end
            else
            begin
                req[k].w    = 8'd0;
                req[k].bone = 8'd0;
            end
            req[k].own_ok = (req[k].w != 8'd0) &&
                            ({1'b0, req[k].bone} < own_cnt_reg) &&
                            (17'(req[k].bone) < 17'(MAX_BONES));
            req[k].remap  = rmv_reg[req[k].bone[AW-1:0]];
        end
    end

    for (genvar k = 0; k < BONE_SLOTS; k++)
    begin : g_lane
        bsr_lane #(
            .MAX_BONES (MAX_BONES),
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .wr        (wr),
            .req       (req[k]),
            .owner_cnt (owner_cnt_reg),
            .vec       (vec2_reg),
            .res       (lres[k])
        );
    end

    always_comb
    begin
        flt_next = 1'b0;
        for (int k = 0; k < BONE_SLOTS; k++)
            flt_next = flt_next | lres[k].fault;
        for (int r = 0; r < 6; r++)
        begin
            logic [ACW-1:0] s;
            s = '0;
            for (int k = 0; k < BONE_SLOTS; k++)
                s = s + {{(ACW-33){lres[k].val[r][32]}}, lres[k].val[r]};
            if (!s[ACW-1] && (|s[ACW-2:31]))
                sum_next[r] = 32'h7FFF_FFFF;
            else if (s[ACW-1] && !(&s[ACW-2:31]))
                sum_next[r] = 32'h8000_0000;
            else
                sum_next[r] = s[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_cnt_reg   <= 9'd0;
            owner_cnt_reg <= 9'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                bsr_pkg::CFG_OWN_CNT:   own_cnt_reg   <= cfg_wdata;
                bsr_pkg::CFG_OWNER_CNT: owner_cnt_reg <= cfg_wdata;
                default:                own_cnt_reg   <= own_cnt_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rmv_reg     <= '0;
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (acc && ent_ok && (s_tuser == bsr_pkg::OP_SET_MAP))
                rmv_reg[entry[AW-1:0]] <= 1'b1;
            else if (acc && ent_ok && (s_tuser == bsr_pkg::OP_CLEAR_MAP))
                rmv_reg[entry[AW-1:0]] <= 1'b0;
            if (adv)
            begin
                vld_reg     <= {vld_reg[LAT-2:0], vtx};
                out_vld_reg <= vld_reg[LAT-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vec1_reg    <= vec_in;
            vec2_reg    <= vec1_reg;
            out_reg     <= sum_next;
            out_flt_reg <= flt_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;
    assign m_tuser  = out_flt_reg;

    a_no_result_for_writes: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && (s_tuser != bsr_pkg::OP_SKIN)) |=> !vld_reg[0])
        else $error("non-vertex request started a result");

    a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !m_tready) |=> ($stable(vld_reg) && out_vld_reg))
        else $error("pipeline moved during output stall");

    a_map_set: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && ent_ok && (s_tuser == bsr_pkg::OP_SET_MAP))
            |=> rmv_reg[$past(entry[AW-1:0])])
        else $error("remap valid bit not set");

endmodule
